FILE: hw/rtl/mrfc_pkg.sv
// Shared types, codes and CRC helper for the Modbus RTU framer/checker.
package mrfc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic MODE_TX = 1'b0;
	localparam logic MODE_RX = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_TX_LO = 4'b0010,
		S_TX_HI = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/modbus_rtu_frame_crc.sv
// Modbus RTU framer/checker top level: CRC-16 framing, frame store and result sequencer.
// Transmit byte: one result, registered in the cycle after the transfer; with frame_last
//   two CRC bytes follow one per cycle unless stalled; the next byte waits for the high byte.
// Receive byte: stored in memory; a single-result frame shows its result in the cycle after
//   the last transfer; payload bytes go via rdata_q and S_DRAIN, one per cycle unless stalled.
// Reset clears CRCs, byte count, overflow flag and output valid; the frame memory is not cleared.
module modbus_rtu_frame_crc import mrfc_pkg::*; #(
	parameter int FRAME_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic [1:0] status
);

	localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam logic [CW-1:0] FULL = CW'(FRAME_BYTES);

	logic [7:0]    mem [FRAME_BYTES];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_addr;

	state_t        state_q;
	logic [15:0]   tx_crc_q;
	logic [15:0]   rx_crc_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [7:0]    b1_q;
	logic [7:0]    b2_q;
	logic [CW-1:0] plen_q;
	logic          ok_q;
	logic [AW-1:0] idx_q;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          run_last_q;
	logic [1:0]    status_q;

	logic          slot_free;
	logic          acc;
	logic          acc_tx;
	logic          acc_rx;
	logic          store_en;
	logic [15:0]   tx_crc_nx;
	logic [15:0]   rx_crc_nx;
	logic [CW-1:0] count_nx;
	logic          ovf_nx;
	logic          crc_ok;
	logic          drain_load;
	logic          drain_end;
	logic          drain_start;
	logic          out_load;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign acc_tx    = acc && (mode == MODE_TX);
	assign acc_rx    = acc && (mode == MODE_RX);
	assign store_en  = acc_rx && !ovf_q && (count_q < FULL);

	assign tx_crc_nx = crc_fold(tx_crc_q, data_byte);
	assign rx_crc_nx = (count_q >= CW'(2)) ? crc_fold(rx_crc_q, b2_q) : rx_crc_q;
	assign count_nx  = store_en ? count_q + 1'b1 : count_q;
	assign ovf_nx    = ovf_q || (count_q == FULL);
	assign crc_ok    = ({data_byte, b1_q} == rx_crc_nx);

	assign drain_load  = (state_q == S_DRAIN) && slot_free;
	assign drain_end   = (CW'(idx_q) + 1'b1) == plen_q;
	assign drain_start = acc_rx && frame_last && !ovf_nx && (count_nx > CW'(2));
	assign out_load    = acc_tx || (acc_rx && frame_last && !drain_start) ||
		(((state_q == S_TX_LO) || (state_q == S_TX_HI)) && slot_free) || drain_load;

	always_comb begin
		if (state_q != S_DRAIN) begin
			rd_addr = '0;
		end else if (drain_load) begin
			rd_addr = idx_q + 1'b1;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[count_q[AW-1:0]] <= data_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tx_crc_q    <= CRC_INIT;
			rx_crc_q    <= CRC_INIT;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_tx) begin
						tx_crc_q <= tx_crc_nx;
						if (frame_last) begin
							state_q <= S_TX_LO;
						end
					end else if (acc_rx) begin
						if (frame_last) begin
							rx_crc_q <= CRC_INIT;
							count_q  <= '0;
							ovf_q    <= 1'b0;
							if (drain_start) begin
								idx_q   <= '0;
								state_q <= S_DRAIN;
							end
						end else if (store_en) begin
							rx_crc_q <= rx_crc_nx;
							count_q  <= count_nx;
						end else begin
							ovf_q <= ovf_nx;
						end
					end
				end
				S_TX_LO: begin
					if (slot_free) begin
						state_q <= S_TX_HI;
					end
				end
				S_TX_HI: begin
					if (slot_free) begin
						tx_crc_q <= CRC_INIT;
						state_q  <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (drain_load) begin
						idx_q <= idx_q + 1'b1;
						if (drain_end) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_tx) begin
			out_byte_q <= data_byte;
			run_last_q <= !frame_last;
			status_q   <= ST_OK;
		end
		if (acc_rx) begin
			b1_q   <= store_en ? data_byte : b1_q;
			b2_q   <= store_en ? b1_q : b2_q;
			plen_q <= count_nx - CW'(2);
			ok_q   <= crc_ok;
			out_byte_q <= 8'h00;
			run_last_q <= 1'b1;
			if (ovf_nx) begin
				status_q <= ST_OVERFLOW;
			end else if (count_nx < CW'(2)) begin
				status_q <= ST_SHORT;
			end else begin
				status_q <= crc_ok ? ST_OK : ST_MISMATCH;
			end
		end
		if (state_q == S_TX_LO && slot_free) begin
			out_byte_q <= tx_crc_q[7:0];
			run_last_q <= 1'b0;
			status_q   <= ST_OK;
		end
		if (state_q == S_TX_HI && slot_free) begin
			out_byte_q <= tx_crc_q[15:8];
			run_last_q <= 1'b1;
			status_q   <= ST_OK;
		end
		if (drain_load) begin
			out_byte_q <= ok_q ? rdata_q : 8'h00;
			run_last_q <= drain_end;
			status_q   <= ok_q ? ST_OK : ST_MISMATCH;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign status    = status_q;

endmodule

FILE: dv/mrfc_frame_checker.sv
// Checker for the Modbus RTU framer: predicts CRC framing results and compares transfers.
module mrfc_frame_checker import mrfc_pkg::*; #(
	parameter int FRAME_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic [1:0] status,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = $clog2(FRAME_BYTES + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] st;
	} frame_out_t;

	frame_out_t  bytes_due[$];
	logic [15:0] tx_crc;
	logic [15:0] rx_crc;
	logic [7:0]  rx_mem [FRAME_BYTES];
	logic [CW-1:0] rx_cnt;
	logic        rx_ovf;
	int          err_cnt = 0;
	int          due_cnt = 0;

	assign errors  = err_cnt;
	assign pending = due_cnt;

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic frame_out_t mk(input logic [7:0] d, input logic l, input logic [1:0] s);
		frame_out_t f;
		f.data = d;
		f.last = l;
		f.st   = s;
		return f;
	endfunction

	task automatic predict_frame_bytes(input logic m, input logic [7:0] b, input logic l);
		logic [15:0] got_crc;
		logic [1:0]  st;
		int          plen;
		if (m == MODE_TX) begin
			tx_crc = crc16_step(tx_crc, b);
			bytes_due.push_back(mk(b, !l, ST_OK));
			if (l) begin
				bytes_due.push_back(mk(tx_crc[7:0], 1'b0, ST_OK));
				bytes_due.push_back(mk(tx_crc[15:8], 1'b1, ST_OK));
				tx_crc = CRC_INIT;
			end
		end else begin
			if (!rx_ovf) begin
				if (rx_cnt < FRAME_BYTES) begin
					if (rx_cnt >= 2)
						rx_crc = crc16_step(rx_crc, rx_mem[rx_cnt - 2]);
					rx_mem[rx_cnt] = b;
					rx_cnt++;
				end else begin
					rx_ovf = 1'b1;
				end
			end
			if (l) begin
				if (rx_ovf) begin
					bytes_due.push_back(mk(8'h00, 1'b1, ST_OVERFLOW));
				end else if (rx_cnt < 2) begin
					bytes_due.push_back(mk(8'h00, 1'b1, ST_SHORT));
				end else begin
					got_crc = {rx_mem[rx_cnt - 1], rx_mem[rx_cnt - 2]};
					st = (got_crc == rx_crc) ? ST_OK : ST_MISMATCH;
					plen = int'(rx_cnt) - 2;
					if (plen == 0) begin
						bytes_due.push_back(mk(8'h00, 1'b1, st));
					end else begin
						for (int i = 0; i < plen; i++)
							bytes_due.push_back(mk((st == ST_OK) ? rx_mem[i] : 8'h00,
								i == plen - 1, st));
					end
				end
				rx_crc = CRC_INIT;
				rx_cnt = '0;
				rx_ovf = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_out_t exp_out;
		if (!arst_n) begin
			tx_crc = CRC_INIT;
			rx_crc = CRC_INIT;
			rx_cnt = '0;
			rx_ovf = 1'b0;
			bytes_due.delete();
			due_cnt <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					$display("%0t ns: unexpected transfer, expected none, actual %02h/%0d/%0d",
						$time, out_byte, run_last, status);
					err_cnt++;
				end else begin
					exp_out = bytes_due.pop_front();
					if (out_byte !== exp_out.data) begin
						$display("%0t ns: out_byte expected %02h actual %02h",
							$time, exp_out.data, out_byte);
						err_cnt++;
					end
					if (run_last !== exp_out.last) begin
						$display("%0t ns: run_last expected %0d actual %0d",
							$time, exp_out.last, run_last);
						err_cnt++;
					end
					if (status !== exp_out.st) begin
						$display("%0t ns: status expected %0d actual %0d",
							$time, exp_out.st, status);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_frame_bytes(mode, data_byte, frame_last);
			due_cnt <= bytes_due.size();
		end
	end

endmodule

FILE: dv/tb_modbus_rtu_frame_crc.sv
// Testbench top for the Modbus RTU framer/checker: stimulus, handshake pacing and verdict.
module tb_modbus_rtu_frame_crc import mrfc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_BYTES = 64;
	localparam int STALL_LIMIT = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       mode = MODE_TX;
	logic [7:0] data_byte = 8'h00;
	logic       frame_last = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       run_last;
	logic [1:0] status;

	int errors;
	int pending;
	int snd_pct = 34;
	int rcv_pct = 81;
	int sent = 0;
	int stall_cycles = 0;

	modbus_rtu_frame_crc #(
		.FRAME_BYTES(FRAME_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.data_byte (data_byte),
		.frame_last(frame_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.status    (status)
	);

	mrfc_frame_checker #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.data_byte (data_byte),
		.frame_last(frame_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.status    (status),
		.errors    (errors),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send(input logic m, input logic [7:0] b, input logic l);
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		data_byte  <= b;
		frame_last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_tx_payload(input int n);
		for (int i = 0; i < n; i++)
			send(MODE_TX, 8'($urandom), i == n - 1);
	endtask

	task automatic send_rx_frame(input logic [7:0] pl[$], input bit corrupt, input bit mix_tx);
		logic [15:0] c;
		logic [7:0]  fr[$];
		int          k;
		c = CRC_INIT;
		foreach (pl[i]) c = crc_fold(c, pl[i]);
		fr = pl;
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		if (corrupt) begin
			k = $urandom_range(fr.size() - 1);
			fr[k] = fr[k] ^ (8'h01 << $urandom_range(7));
		end
		foreach (fr[i]) begin
			if (mix_tx && $urandom_range(9) == 0)
				send(MODE_TX, 8'($urandom), 1'($urandom_range(1)));
			send(MODE_RX, fr[i], i == fr.size() - 1);
		end
	endtask

	task automatic random_traffic(input int upto);
		int          r;
		int          n;
		logic [7:0]  pl[$];
		while (sent < upto) begin
			r = $urandom_range(99);
			pl.delete();
			repeat ($urandom_range(6)) pl.push_back(8'($urandom));
			if (r < 35) begin
				send_tx_payload($urandom_range(1, 6));
			end else if (r < 70) begin
				send_rx_frame(pl, 1'b0, 1'b1);
			end else if (r < 85) begin
				send_rx_frame(pl, 1'b1, 1'b1);
			end else if (r < 92) begin
				send(MODE_RX, 8'($urandom), 1'b1);
			end else begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					send(MODE_RX, 8'($urandom), i == n - 1);
			end
		end
	endtask

	initial begin
		logic [15:0] c;
		logic [7:0]  pl[$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// transmit: extremes, multi-byte payload and single-byte payload
		send(MODE_TX, 8'h00, 1'b0);
		send(MODE_TX, 8'hFF, 1'b0);
		send(MODE_TX, 8'hA5, 1'b1);
		send(MODE_TX, 8'hFF, 1'b1);
		// receive: too short, empty payload good and bad, known good frame, bad frame
		send(MODE_RX, 8'h5A, 1'b1);
		pl.delete();
		send_rx_frame(pl, 1'b0, 1'b0);
		send_rx_frame(pl, 1'b1, 1'b0);
		pl = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A};
		send_rx_frame(pl, 1'b0, 1'b0);
		pl = '{8'h80};
		send_rx_frame(pl, 1'b1, 1'b0);
		// transmit bytes interleaved with a receive frame
		c = crc_fold(CRC_INIT, 8'h7E);
		send(MODE_RX, 8'h7E, 1'b0);
		send(MODE_TX, 8'hC3, 1'b1);
		send(MODE_RX, c[7:0], 1'b0);
		send(MODE_TX, 8'h3C, 1'b0);
		send(MODE_RX, c[15:8], 1'b1);

		random_traffic(45);
		pl.delete();
		repeat (FRAME_BYTES - 2) pl.push_back(8'($urandom));
		send_rx_frame(pl, 1'b0, 1'b0);
		drain();

		snd_pct = 81;
		rcv_pct = 34;
		random_traffic(150);
		pl.push_back(8'($urandom));
		send_rx_frame(pl, 1'b0, 1'b0);
		drain();

		snd_pct = 0;
		rcv_pct = 0;
		random_traffic(230);
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/mrfc_pkg.sv
hw/rtl/modbus_rtu_frame_crc.sv
dv/mrfc_frame_checker.sv
dv/tb_modbus_rtu_frame_crc.sv
